### src/bpf_pkg.sv
// bpf_pkg: shared types and constants for the bezier path follower
// no dependencies; imported by bpf_lerp and bezier_path_follower_core
package bpf_pkg;

  localparam int unsigned SEG_W    = 5;
  localparam int unsigned PHASE_W  = 16;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned NPTS_W   = 5;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned MOD_K_W  = 3;
  localparam int unsigned STEP_W   = 3;

  localparam logic [NPTS_W-1:0]   NPTS_RESET   = NPTS_W'(2);
  localparam logic [HANDLE_W-1:0] HANDLE_RESET = HANDLE_W'(10240);
  localparam logic [MOD_K_W-1:0]  MOD_K_FIRST  = MOD_K_W'(SEG_W - 1);
  localparam logic [STEP_W-1:0]   STEP_LAST    = STEP_W'(5);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic CFG_IDX_POINTS = 1'b0;
  localparam logic CFG_IDX_HANDLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_RD0,
    ST_RD1,
    ST_LOAD,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_e;

endpackage

### src/bezier_path_follower_core.sv
// bezier_path_follower_core: cubic bezier path follower over stored 2d points
// uses bpf_pkg and bpf_lerp; points live in two synchronous memories
// a tick is accepted in ST_IDLE, runs 5 remainder steps, reads in RD0/RD1/LOAD,
//   6 lerps on a per-axis multiplier (ST_MUL then ST_ADD each) and ST_DONE; no write or
//   tick is accepted until it ends, and a stalled output holds it in ST_DONE
// reset: time, segment, config and control registers cleared to defaults, point memories and datapath undefined
module bezier_path_follower_core import bpf_pkg::*; #(
  parameter int unsigned MAX_POINTS = 16,
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic        [HANDLE_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic        [IDX_W-1:0]       point_index_i,
  input  logic signed [COORD_BITS-1:0]  point_x_i,
  input  logic signed [COORD_BITS-1:0]  point_y_i,
  input  logic        [PHASE_W-1:0]     tick_delta_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_BITS-1:0]  pos_x_o,
  output logic signed [COORD_BITS-1:0]  pos_y_o,
  output logic        [IDX_W-1:0]       segment_index_o,
  output logic        [PHASE_W-1:0]     phase_o
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned VW = ((COORD_BITS > HANDLE_W + 1) ? COORD_BITS : HANDLE_W + 1) + 2;
  localparam logic signed [VW-1:0] SAT_HI = VW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);

  state_e state_q, state_d;

  logic [NPTS_W-1:0]   npts_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [SEG_W-1:0]    seg_q;
  logic [PHASE_W-1:0]  phase_q;
  logic [MOD_K_W-1:0]  mod_k_q;
  logic [STEP_W-1:0]   step_q;

  logic signed [COORD_BITS-1:0] mem_x [MAX_POINTS];
  logic signed [COORD_BITS-1:0] mem_y [MAX_POINTS];
  logic signed [COORD_BITS-1:0] rd_x_q, rd_y_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;

  logic signed [VW-1:0] cx_q [4];
  logic signed [VW-1:0] cy_q [4];
  logic signed [VW-1:0] res_x, res_y;
  logic signed [VW-1:0] hv, px, py;

  logic                  out_valid_q;
  logic signed [COORD_BITS-1:0] pos_x_q, pos_y_q;
  logic [IDX_W-1:0]      seg_out_q;
  logic [PHASE_W-1:0]    phase_out_q;

  logic                in_acc, out_take, out_load, mul_en;
  logic [SEG_W-1:0]    n_eff, segs, seg_nx;
  logic [2*SEG_W-1:0]  dvs;
  logic [PHASE_W:0]    sum;

  // config port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      npts_q   <= NPTS_RESET;
      handle_q <= HANDLE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IDX_POINTS: npts_q   <= cfg_data_i[NPTS_W-1:0];
        CFG_IDX_HANDLE: handle_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (npts_q < NPTS_W'(2)) begin
      n_eff = SEG_W'(2);
    end else if (32'(npts_q) > MAX_POINTS) begin
      n_eff = SEG_W'(MAX_POINTS);
    end else begin
      n_eff = SEG_W'(npts_q);
    end
  end

  assign segs   = n_eff - SEG_W'(1);
  assign seg_nx = seg_q + SEG_W'(1);
  assign dvs    = (2*SEG_W)'(segs) << mod_k_q;
  assign sum    = (PHASE_W+1)'(phase_q) + (PHASE_W+1)'(tick_delta_i);

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_take = out_valid_q && !out_stall_i;

  // point memories
  assign wr_en   = in_acc && (command_i == CMD_WRITE) && (32'(point_index_i) < MAX_POINTS);
  assign wr_addr = AW'(point_index_i);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[wr_addr] <= point_x_i;
      mem_y[wr_addr] <= point_y_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_x_q <= mem_x[rd_addr];
    rd_y_q <= mem_y[rd_addr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && command_i == CMD_TICK) state_d = ST_MOD;
      ST_MOD:  if (mod_k_q == '0) state_d = ST_RD0;
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_LOAD;
      ST_LOAD: state_d = ST_MUL;
      ST_MUL:  state_d = ST_ADD;
      ST_ADD:  state_d = (step_q == STEP_LAST) ? ST_DONE : ST_MUL;
      ST_DONE: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    rd_addr    = AW'(seg_q);
    mul_en     = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_RD0:  rd_addr = AW'(seg_q);
      ST_RD1:  rd_addr = AW'(seg_nx);
      ST_MUL:  mul_en = 1'b1;
      ST_DONE: out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seg_q   <= '0;
      phase_q <= '0;
      mod_k_q <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && command_i == CMD_TICK) begin
            phase_q <= sum[PHASE_W-1:0];
            seg_q   <= seg_q + SEG_W'(sum[PHASE_W]);
            mod_k_q <= MOD_K_FIRST;
          end
        end
        ST_MOD: begin
          if ((2*SEG_W)'(seg_q) >= dvs) begin
            seg_q <= seg_q - SEG_W'(dvs);
          end
          mod_k_q <= mod_k_q - MOD_K_W'(1);
        end
        ST_LOAD: step_q <= '0;
        ST_ADD:  step_q <= step_q + STEP_W'(1);
        default: ;
      endcase
    end
  end

  // control points and in-place de casteljau reduction
  assign hv = VW'(signed'({1'b0, handle_q}));
  assign px = VW'(rd_x_q);
  assign py = VW'(rd_y_q);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_RD1: begin
        // rd data holds the segment start point
        cx_q[0] <= px;
        cx_q[1] <= px + hv;
        cy_q[0] <= py;
        cy_q[1] <= py;
      end
      ST_LOAD: begin
        cx_q[2] <= px - hv;
        cx_q[3] <= px;
        cy_q[2] <= py;
        cy_q[3] <= py;
      end
      ST_ADD: begin
        unique case (step_q)
          3'd0, 3'd1: begin
            cx_q[0] <= cx_q[1];
            cx_q[1] <= cx_q[2];
            cx_q[2] <= cx_q[3];
            cx_q[3] <= res_x;
            cy_q[0] <= cy_q[1];
            cy_q[1] <= cy_q[2];
            cy_q[2] <= cy_q[3];
            cy_q[3] <= res_y;
          end
          3'd2: begin
            cx_q[0] <= cx_q[2];
            cx_q[1] <= cx_q[3];
            cx_q[2] <= res_x;
            cy_q[0] <= cy_q[2];
            cy_q[1] <= cy_q[3];
            cy_q[2] <= res_y;
          end
          3'd3: begin
            cx_q[0] <= cx_q[1];
            cx_q[1] <= cx_q[2];
            cx_q[2] <= res_x;
            cy_q[0] <= cy_q[1];
            cy_q[1] <= cy_q[2];
            cy_q[2] <= res_y;
          end
          3'd4: begin
            cx_q[0] <= cx_q[2];
            cx_q[1] <= res_x;
            cy_q[0] <= cy_q[2];
            cy_q[1] <= res_y;
          end
          3'd5: begin
            cx_q[0] <= res_x;
            cy_q[0] <= res_y;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  bpf_lerp #(.VW(VW)) u_lerp_x (
    .clk_i    (clk_i),
    .mul_en_i (mul_en),
    .a_i      (cx_q[0]),
    .b_i      (cx_q[1]),
    .t_i      (phase_q),
    .res_o    (res_x)
  );

  bpf_lerp #(.VW(VW)) u_lerp_y (
    .clk_i    (clk_i),
    .mul_en_i (mul_en),
    .a_i      (cy_q[0]),
    .b_i      (cy_q[1]),
    .t_i      (phase_q),
    .res_o    (res_y)
  );

  // output register with saturation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      priority if (cx_q[0] > SAT_HI) begin
        pos_x_q <= COORD_BITS'(SAT_HI);
      end else if (cx_q[0] < SAT_LO) begin
        pos_x_q <= COORD_BITS'(SAT_LO);
      end else begin
        pos_x_q <= COORD_BITS'(cx_q[0]);
      end
      priority if (cy_q[0] > SAT_HI) begin
        pos_y_q <= COORD_BITS'(SAT_HI);
      end else if (cy_q[0] < SAT_LO) begin
        pos_y_q <= COORD_BITS'(SAT_LO);
      end else begin
        pos_y_q <= COORD_BITS'(cy_q[0]);
      end
      seg_out_q   <= seg_q[IDX_W-1:0];
      phase_out_q <= phase_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pos_x_o         = pos_x_q;
  assign pos_y_o         = pos_y_q;
  assign segment_index_o = seg_out_q;
  assign phase_o         = phase_out_q;

endmodule

### src/bpf_lerp.sv
// bpf_lerp: one fixed point lerp a + round((b - a) * t / 2^16)
// registered product, then rounding add; uses bpf_pkg
module bpf_lerp import bpf_pkg::*; #(
  parameter int unsigned VW = 26
) (
  input  logic                       clk_i,
  input  logic                       mul_en_i,
  input  logic signed [VW-1:0]       a_i,
  input  logic signed [VW-1:0]       b_i,
  input  logic        [PHASE_W-1:0]  t_i,
  output logic signed [VW-1:0]       res_o
);

  localparam int unsigned DW = VW + 1;
  localparam int unsigned PW = DW + PHASE_W + 1;

  logic signed [DW-1:0]      diff;
  logic signed [PHASE_W:0]   t_s;
  logic signed [PW-1:0]      prod_d;
  logic signed [PW-1:0]      prod_q;
  logic signed [VW-1:0]      a_q;
  logic signed [PW-1:0]      rnd;

  assign diff   = DW'(b_i) - DW'(a_i);
  assign t_s    = signed'({1'b0, t_i});
  assign prod_d = PW'(diff) * PW'(t_s);

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
      a_q    <= a_i;
    end
  end

  assign rnd   = (prod_q + PW'(33'sd32768)) >>> PHASE_W;
  assign res_o = a_q + VW'(rnd);

endmodule
